// ===== hw/rtl/rfd_pkg.sv =====
// ---------------------------------------------------------------------------
// rfd_pkg: receiver frame deframer shared definitions
// Sync and id codes, kind codes and the result record passed to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

  localparam logic [7:0] SYNC_A  = 8'hFF;
  localparam logic [7:0] SYNC_B  = 8'h00;
  localparam logic [7:0] ID_AUG  = 8'h5C;
  localparam logic [7:0] ID_STAT = 8'h53;
  localparam logic [7:0] ID_ACK  = 8'h96;

  localparam int unsigned SUM_W = 17;
  localparam int unsigned N_CAP = 5;

  localparam logic [1:0] KIND_AUG  = 2'd0;
  localparam logic [1:0] KIND_STAT = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [7:0]  payload_length;
    logic        checksum_ok;
    logic [15:0] received_checksum;
    logic [7:0]  payload_first;
    logic [7:0]  payload_second;
    logic [7:0]  payload_third;
    logic [7:0]  payload_sixth;
    logic [7:0]  payload_seventh;
  } frame_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rfd_parser.sv =====
// ---------------------------------------------------------------------------
// rfd_parser: frame phase tracker and checksum datapath
// Consumes one byte per accepted beat and flags a finished frame on the beat
// that carries the high checksum byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfd_parser (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  byte_valid,
  input  wire logic [7:0]            rx_byte,
  output logic                       res_valid,
  output rfd_pkg::frame_result_t     res
);

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_ID    = 3'd2,
    PH_LEN   = 3'd3,
    PH_PAY   = 3'd4,
    PH_CKLO  = 3'd5,
    PH_CKHI  = 3'd6
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [7:0]                   count_r, count_nxt;
  logic [7:0]                   length_r, length_nxt;
  logic [rfd_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic [7:0]                   cap_r   [rfd_pkg::N_CAP];
  logic [7:0]                   cap_nxt [rfd_pkg::N_CAP];
  logic [7:0]                   ck_lo_r, ck_lo_nxt;

  logic [rfd_pkg::SUM_W-1:0]    sum_add;
  logic [7:0]                   count_inc;
  logic [15:0]                  ck_full;
  logic                         ck_match;
  logic                         id_known;

  assign sum_add   = sum_r + {{(rfd_pkg::SUM_W-8){1'b0}}, rx_byte};
  assign count_inc = count_r + 8'd1;
  assign ck_full   = {rx_byte, ck_lo_r};
  assign ck_match  = (sum_r == {1'b0, ck_full});
  assign id_known  = (rx_byte == rfd_pkg::ID_AUG) || (rx_byte == rfd_pkg::ID_STAT) ||
                     (rx_byte == rfd_pkg::ID_ACK);

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    length_nxt = length_r;
    sum_nxt    = sum_r;
    kind_nxt   = kind_r;
    ck_lo_nxt  = ck_lo_r;
    for (int i = 0; i < rfd_pkg::N_CAP; i++) cap_nxt[i] = cap_r[i];
    res_valid  = 1'b0;

    if (byte_valid) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (rx_byte == rfd_pkg::SYNC_A) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (rx_byte == rfd_pkg::SYNC_B)      phase_nxt = PH_ID;
          else if (rx_byte != rfd_pkg::SYNC_A) phase_nxt = PH_HUNT;
        end
        PH_ID: begin
          if (id_known) begin
            if (rx_byte == rfd_pkg::ID_AUG)       kind_nxt = rfd_pkg::KIND_AUG;
            else if (rx_byte == rfd_pkg::ID_STAT) kind_nxt = rfd_pkg::KIND_STAT;
            else                                  kind_nxt = rfd_pkg::KIND_ACK;
            // sync bytes plus id start the sum
            sum_nxt = {{(rfd_pkg::SUM_W-8){1'b0}}, rfd_pkg::SYNC_A}
                    + {{(rfd_pkg::SUM_W-8){1'b0}}, rfd_pkg::SYNC_B}
                    + {{(rfd_pkg::SUM_W-8){1'b0}}, rx_byte};
            for (int i = 0; i < rfd_pkg::N_CAP; i++) cap_nxt[i] = 8'd0;
            count_nxt = 8'd0;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = (rx_byte == rfd_pkg::SYNC_A) ? PH_SYNC2 : PH_HUNT;
          end
        end
        PH_LEN: begin
          length_nxt = rx_byte;
          sum_nxt    = sum_add;
          count_nxt  = 8'd0;
          phase_nxt  = (rx_byte == 8'd0) ? PH_CKLO : PH_PAY;
        end
        PH_PAY: begin
          case (count_r)
            8'd0:    cap_nxt[0] = rx_byte;
            8'd1:    cap_nxt[1] = rx_byte;
            8'd2:    cap_nxt[2] = rx_byte;
            8'd5:    cap_nxt[3] = rx_byte;
            8'd6:    cap_nxt[4] = rx_byte;
            default: ;
          endcase
          sum_nxt   = sum_add;
          count_nxt = count_inc;
          if (count_inc == length_r) phase_nxt = PH_CKLO;
        end
        PH_CKLO: begin
          ck_lo_nxt = rx_byte;
          phase_nxt = PH_CKHI;
        end
        PH_CKHI: begin
          res_valid = 1'b1;
          phase_nxt = PH_HUNT;
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    res.frame_kind        = kind_r;
    res.payload_length    = length_r;
    res.checksum_ok       = ck_match;
    res.received_checksum = ck_full;
    res.payload_first     = ck_match ? cap_r[0] : 8'd0;
    res.payload_second    = ck_match ? cap_r[1] : 8'd0;
    res.payload_third     = ck_match ? cap_r[2] : 8'd0;
    res.payload_sixth     = ck_match ? cap_r[3] : 8'd0;
    res.payload_seventh   = ck_match ? cap_r[4] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      count_r  <= 8'd0;
      length_r <= 8'd0;
      sum_r    <= '0;
      kind_r   <= 2'd0;
      ck_lo_r  <= 8'd0;
      for (int i = 0; i < rfd_pkg::N_CAP; i++) cap_r[i] <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      length_r <= length_nxt;
      sum_r    <= sum_nxt;
      kind_r   <= kind_nxt;
      ck_lo_r  <= ck_lo_nxt;
      for (int i = 0; i < rfd_pkg::N_CAP; i++) cap_r[i] <= cap_nxt[i];
    end
  end

`ifndef NO_ASSERTIONS
  // a result only comes out of the high checksum byte
  a_res_phase: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (byte_valid && phase_r == PH_CKHI))
    else $error("result outside checksum phase");

  // failed checksum never exposes payload
  a_res_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res.checksum_ok) |->
      (res.payload_first == 8'd0 && res.payload_second == 8'd0 &&
       res.payload_third == 8'd0 && res.payload_sixth == 8'd0 &&
       res.payload_seventh == 8'd0))
    else $error("payload leaked on bad checksum");

  // zero length skips straight to checksum
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid && phase_r == PH_LEN && rx_byte == 8'd0) |=> (phase_r == PH_CKLO))
    else $error("zero length did not skip payload");

  // payload count stays below the length while in payload phase
  a_pay_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAY) |-> (count_r < length_r))
    else $error("payload count overran length");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/receiver_frame_deframer.sv =====
// ---------------------------------------------------------------------------
// receiver_frame_deframer: serial receiver frame deframer
// Hunts for FF 00 id, reads length, payload and little-endian checksum and
// reports one record per frame.
// ---------------------------------------------------------------------------
//  channel | ports                          | beat
//  --------+--------------------------------+-------------------------------
//  in      | in_valid in_ready in_rx_byte   | one received byte
//  out     | out_valid out_ready out_*      | one frame record at frame end
//
// One byte per cycle while in_ready is high (low only while a record waits
// and out_ready is low); the phase tracker and sum adder finish each byte in
// the cycle it is accepted; the record lands in a single output register.
// Synchronous active-low reset returns to hunting and clears all but out_r.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module receiver_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_frame_kind,
  output logic [7:0]       out_payload_length,
  output logic             out_checksum_ok,
  output logic [15:0]      out_received_checksum,
  output logic [7:0]       out_payload_first,
  output logic [7:0]       out_payload_second,
  output logic [7:0]       out_payload_third,
  output logic [7:0]       out_payload_sixth,
  output logic [7:0]       out_payload_seventh
);

  logic                   in_fire;
  logic                   res_valid;
  rfd_pkg::frame_result_t res;
  rfd_pkg::frame_result_t out_r;
  logic                   out_valid_r, out_valid_nxt;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  rfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_fire),
    .rx_byte    (in_rx_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid)      out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_frame_kind        = out_r.frame_kind;
  assign out_payload_length    = out_r.payload_length;
  assign out_checksum_ok       = out_r.checksum_ok;
  assign out_received_checksum = out_r.received_checksum;
  assign out_payload_first     = out_r.payload_first;
  assign out_payload_second    = out_r.payload_second;
  assign out_payload_third     = out_r.payload_third;
  assign out_payload_sixth     = out_r.payload_sixth;
  assign out_payload_seventh   = out_r.payload_seventh;

`ifndef NO_ASSERTIONS
  // a waiting record is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !res_valid)
    else $error("record overwritten while stalled");

  // a new record always shows up the cycle after it is produced
  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> out_valid_r)
    else $error("record lost");

  // the output register empties only through a taken beat
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ready))
    else $error("record dropped without handshake");
`endif

endmodule

`default_nettype wire
